/* rtl/rbpm_pkg.sv */
// Shared types and constants for the reference-counted buffer pool manager.
`default_nettype none
package rbpm_pkg;

	localparam int POOL_SIZE_DEF = 32;

	localparam logic [1:0] OP_INIT    = 2'd0;
	localparam logic [1:0] OP_ALLOC   = 2'd1;
	localparam logic [1:0] OP_ADDREF  = 2'd2;
	localparam logic [1:0] OP_RELEASE = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOBUF   = 2'd1;
	localparam logic [1:0] ST_DYNAMIC = 2'd2;
	localparam logic [1:0] ST_NOTUSED = 2'd3;

	localparam logic [1:0] TYPE_ACL_IN = 2'd3;
	localparam logic [7:0] REF_MAX     = 8'd255;

	typedef struct packed {
		logic [1:0] op;
		logic       in_interrupt;
		logic [1:0] buf_type;
		logic [4:0] buffer_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] out_index;
		logic       out_pool;
		logic [7:0] ref_count;
		logic       freed;
		logic       acl_in_freed;
	} out_item_t;

	typedef struct packed {
		logic [7:0] refs;
		logic       pool;
		logic [1:0] etype;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

endpackage
`default_nettype wire

/* rtl/rbpm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rbpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/refcounted_buffer_pool_manager.sv */
// Top level of the reference-counted buffer pool manager.
//
// Usage:
//  - in channel (in_valid/in_ready/in_item) carries one request beat: init,
//    allocate, add reference or release. out channel (out_valid/out_ready/
//    out_item) returns exactly one result beat per request, in order.
//  - cfg channel (cfg_valid/cfg_ready/cfg_data) writes irq_reserve; it is
//    always ready and only matters when init runs.
//  - Allocate, add reference, release and a repeated init have an accept step
//    that reads the link and entry memories and an execute step that modifies,
//    writes back and loads the output register. The next request is taken right after.
//  - The first init walks the pool, one entry per cycle, before its execute step.
//  - Reset clears both list heads to empty and marks the pool uninitialized;
//    memory contents are undefined until init.
//  - A stalled receiver holds the result in the output register; one more
//    request may be accepted and waits in the execute step until the
//    register frees up.
`default_nettype none
module refcounted_buffer_pool_manager
	import rbpm_pkg::*;
#(
	parameter int POOL_SIZE = POOL_SIZE_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [5:0] cfg_data
);

	localparam int IDX_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int HEAD_W = $clog2(POOL_SIZE + 1);
	localparam int CMP_W  = (HEAD_W > 6) ? HEAD_W : 6;
	localparam logic [HEAD_W-1:0] SENT = HEAD_W'(POOL_SIZE);
	localparam logic [IDX_W-1:0]  LAST = IDX_W'(POOL_SIZE - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INIT = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0]        state_q;
	logic              init_q;
	logic [5:0]        irq_reserve_q;
	logic [HEAD_W-1:0] general_head_q;
	logic [HEAD_W-1:0] reserve_head_q;
	logic [HEAD_W-1:0] split_q;
	logic [IDX_W-1:0]  cnt_q;

	logic [1:0]        op_s1;
	logic              irq_s1;
	logic [1:0]        type_s1;
	logic [4:0]        idx_s1;
	logic              alloc_gen_s1;
	logic              alloc_res_s1;
	logic              ref_ok_s1;
	logic [IDX_W-1:0]  e_s1;

	logic              out_valid_q;
	out_item_t         out_q;

	logic              accept;
	logic              exec_go;
	logic              gen_avail;
	logic              res_avail;
	logic [CMP_W-1:0]  idx_wide;
	logic              idx_in_range;
	logic [IDX_W-1:0]  alloc_e;
	logic [CMP_W-1:0]  res_wide;
	logic [CMP_W-1:0]  res_clamp;
	logic              init_gen;

	logic              link_we;
	logic [IDX_W-1:0]  link_waddr;
	logic [HEAD_W-1:0] link_wdata;
	logic              link_re;
	logic [HEAD_W-1:0] link_rd;
	logic              ent_we;
	logic [IDX_W-1:0]  ent_waddr;
	ent_t              ent_wdata;
	logic              ent_re;
	logic [ENT_W-1:0]  ent_rd_raw;
	ent_t              ent_rd;

	logic [CMP_W-1:0]  e_wide;
	logic [7:0]        new_refs;
	logic [HEAD_W-1:0] pool_head;
	out_item_t         res;
	logic              rel_free;
	logic              head_upd_gen;
	logic              head_upd_res;
	logic [HEAD_W-1:0] head_new;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign exec_go   = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign gen_avail    = general_head_q < SENT;
	assign res_avail    = in_item.in_interrupt && (reserve_head_q < SENT);
	assign alloc_e      = gen_avail ? general_head_q[IDX_W-1:0] : reserve_head_q[IDX_W-1:0];
	assign idx_wide     = CMP_W'(in_item.buffer_index);
	assign idx_in_range = idx_wide < CMP_W'(POOL_SIZE);
	assign res_wide     = CMP_W'(irq_reserve_q);
	assign res_clamp    = (res_wide > CMP_W'(POOL_SIZE)) ? CMP_W'(POOL_SIZE) : res_wide;
	assign init_gen     = HEAD_W'(cnt_q) < split_q;

	assign link_re = accept && (in_item.op == OP_ALLOC) && (gen_avail || res_avail);
	assign ent_re  = accept && (in_item.op == OP_ADDREF || in_item.op == OP_RELEASE)
		&& init_q && idx_in_range;
	assign ent_rd  = ent_t'(ent_rd_raw);

	assign e_wide    = CMP_W'(e_s1);
	assign pool_head = ent_rd.pool ? reserve_head_q : general_head_q;

	always_comb begin
		res          = '0;
		new_refs     = ent_rd.refs;
		rel_free     = 1'b0;
		head_upd_gen = 1'b0;
		head_upd_res = 1'b0;
		head_new     = link_rd;
		ent_we       = 1'b0;
		ent_waddr    = e_s1;
		ent_wdata    = ent_rd;
		link_we      = 1'b0;
		link_waddr   = e_s1;
		link_wdata   = pool_head;
		if (state_q == S_INIT) begin
			ent_we     = 1'b1;
			ent_waddr  = cnt_q;
			ent_wdata  = '{refs: 8'd0, pool: !init_gen, etype: 2'd0};
			link_we    = 1'b1;
			link_waddr = cnt_q;
			link_wdata = init_gen ? general_head_q : reserve_head_q;
		end else begin
			case (op_s1)
				OP_INIT: begin
					res = '0;
				end
				OP_ALLOC: begin
					if (alloc_gen_s1 || alloc_res_s1) begin
						ent_we        = exec_go;
						ent_wdata     = '{refs: 8'd1, pool: alloc_res_s1, etype: type_s1};
						head_upd_gen  = exec_go && alloc_gen_s1;
						head_upd_res  = exec_go && alloc_res_s1;
						head_new      = link_rd;
						res.status    = ST_OK;
						res.out_index = e_wide[4:0];
						res.out_pool  = alloc_res_s1;
						res.ref_count = 8'd1;
					end else begin
						res.status = irq_s1 ? ST_NOBUF : ST_DYNAMIC;
					end
				end
				OP_ADDREF, OP_RELEASE: begin
					res.out_index = idx_s1;
					if (!ref_ok_s1) begin
						res.status = ST_NOTUSED;
					end else if (ent_rd.refs == 8'd0) begin
						res.status   = ST_NOTUSED;
						res.out_pool = ent_rd.pool;
					end else begin
						if (op_s1 == OP_ADDREF) begin
							new_refs = (ent_rd.refs == REF_MAX) ? REF_MAX : ent_rd.refs + 8'd1;
						end else begin
							new_refs = ent_rd.refs - 8'd1;
							rel_free = (new_refs == 8'd0);
						end
						ent_we          = exec_go;
						ent_wdata.refs  = new_refs;
						link_we         = exec_go && rel_free;
						head_upd_gen    = exec_go && rel_free && !ent_rd.pool;
						head_upd_res    = exec_go && rel_free && ent_rd.pool;
						head_new        = HEAD_W'(e_s1);
						res.status       = ST_OK;
						res.out_pool     = ent_rd.pool;
						res.ref_count    = new_refs;
						res.freed        = rel_free;
						res.acl_in_freed = rel_free && (ent_rd.etype == TYPE_ACL_IN);
					end
				end
				default: begin
					res = '0;
				end
			endcase
		end
	end

	rbpm_ram #(
		.WIDTH (HEAD_W),
		.DEPTH (POOL_SIZE)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (link_we),
		.wr_addr (link_waddr),
		.wr_data (link_wdata),
		.rd_en   (link_re),
		.rd_addr (alloc_e),
		.rd_data (link_rd)
	);

	rbpm_ram #(
		.WIDTH (ENT_W),
		.DEPTH (POOL_SIZE)
	) u_ent_ram (
		.clk     (clk),
		.wr_en   (ent_we),
		.wr_addr (ent_waddr),
		.wr_data (ENT_W'(ent_wdata)),
		.rd_en   (ent_re),
		.rd_addr (idx_wide[IDX_W-1:0]),
		.rd_data (ent_rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			init_q         <= 1'b0;
			irq_reserve_q  <= 6'd0;
			general_head_q <= SENT;
			reserve_head_q <= SENT;
			out_valid_q    <= 1'b0;
			cnt_q          <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				irq_reserve_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (in_item.op == OP_INIT && !init_q) begin
							state_q        <= S_INIT;
							general_head_q <= SENT;
							reserve_head_q <= SENT;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_INIT: begin
					if (init_gen) begin
						general_head_q <= HEAD_W'(cnt_q);
					end else begin
						reserve_head_q <= HEAD_W'(cnt_q);
					end
					if (cnt_q == LAST) begin
						init_q  <= 1'b1;
						state_q <= S_EXEC;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (head_upd_gen) begin
							general_head_q <= head_new;
						end
						if (head_upd_res) begin
							reserve_head_q <= head_new;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= in_item.op;
			irq_s1       <= in_item.in_interrupt;
			type_s1      <= in_item.buf_type;
			idx_s1       <= in_item.buffer_index;
			alloc_gen_s1 <= gen_avail;
			alloc_res_s1 <= !gen_avail && res_avail;
			ref_ok_s1    <= init_q && idx_in_range;
			e_s1         <= (in_item.op == OP_ALLOC) ? alloc_e : idx_wide[IDX_W-1:0];
			split_q      <= HEAD_W'(CMP_W'(POOL_SIZE) - res_clamp);
		end
		if (exec_go) begin
			out_q <= res;
		end
	end

	a_out_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_EXEC)
		else $error("result appeared without an execute step");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && out_valid && !out_ready) |=> state_q == S_EXEC)
		else $error("execute step left while output register was full");

	a_init_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INIT |-> !in_ready)
		else $error("request accepted during init walk");

	a_empty_before_init: assert property (@(posedge clk) disable iff (!arst_n)
		(!init_q && state_q != S_INIT) |-> (general_head_q == SENT && reserve_head_q == SENT))
		else $error("free list not empty before init");

endmodule
`default_nettype wire

/* tb/sv/rbpm_pool_checker.sv */
// Checker for the buffer pool manager: predicts every result beat and compares it.
`timescale 1ns / 1ps
module rbpm_pool_checker
	import rbpm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire in_item_t   in_item,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire out_item_t  out_item,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic [5:0] cfg_data,
	output int              errors,
	output int              pending
);

	localparam int POOL = POOL_SIZE_DEF;

	logic [5:0] link [POOL];
	logic [7:0] cnt [POOL];
	logic       pool_of [POOL];
	logic [1:0] kind [POOL];
	logic [5:0] gen_head;
	logic [5:0] rsv_head;
	logic [5:0] reserve_cfg;
	logic       built;

	out_item_t due_results [$];
	int        err_cnt;

	function automatic out_item_t pool_step(in_item_t req);
		out_item_t r;
		logic [5:0] e;
		int split;
		r = '0;
		r.status = ST_OK;
		case (req.op)
			OP_INIT: begin
				if (!built) begin
					split = POOL - ((int'(reserve_cfg) > POOL) ? POOL : int'(reserve_cfg));
					gen_head = 6'(POOL);
					rsv_head = 6'(POOL);
					for (int i = 0; i < POOL; i++) begin
						cnt[i] = 8'd0;
						kind[i] = 2'd0;
						if (i < split) begin
							pool_of[i] = 1'b0;
							link[i] = gen_head;
							gen_head = 6'(i);
						end else begin
							pool_of[i] = 1'b1;
							link[i] = rsv_head;
							rsv_head = 6'(i);
						end
					end
					built = 1'b1;
				end
			end
			OP_ALLOC: begin
				if (int'(gen_head) < POOL) begin
					e = gen_head;
					gen_head = link[e];
					r.out_pool = 1'b0;
				end else if (req.in_interrupt && int'(rsv_head) < POOL) begin
					e = rsv_head;
					rsv_head = link[e];
					r.out_pool = 1'b1;
				end else begin
					e = 6'(POOL);
					r.status = req.in_interrupt ? ST_NOBUF : ST_DYNAMIC;
				end
				if (int'(e) < POOL) begin
					cnt[e] = 8'd1;
					pool_of[e] = r.out_pool;
					kind[e] = req.buf_type;
					r.out_index = e[4:0];
					r.ref_count = 8'd1;
				end
			end
			default: begin
				r.out_index = req.buffer_index;
				if (!built || int'(req.buffer_index) >= POOL) begin
					r.status = ST_NOTUSED;
				end else begin
					e = {1'b0, req.buffer_index};
					r.out_pool = pool_of[e];
					if (cnt[e] == 8'd0) begin
						r.status = ST_NOTUSED;
					end else if (req.op == OP_ADDREF) begin
						if (cnt[e] != REF_MAX)
							cnt[e] = cnt[e] + 8'd1;
						r.ref_count = cnt[e];
					end else begin
						cnt[e] = cnt[e] - 8'd1;
						r.ref_count = cnt[e];
						if (cnt[e] == 8'd0) begin
							if (pool_of[e]) begin
								link[e] = rsv_head;
								rsv_head = e;
							end else begin
								link[e] = gen_head;
								gen_head = e;
							end
							r.freed = 1'b1;
							r.acl_in_freed = (kind[e] == TYPE_ACL_IN);
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < POOL; i++) begin
				link[i] = 6'd0;
				cnt[i] = 8'd0;
				pool_of[i] = 1'b0;
				kind[i] = 2'd0;
			end
			gen_head = 6'(POOL);
			rsv_head = 6'(POOL);
			reserve_cfg = 6'd0;
			built = 1'b0;
			due_results.delete();
			err_cnt = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				reserve_cfg = cfg_data;
			// result beat first, so a stray beat is never matched to this edge's request
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("result beat with no request outstanding");
					err_cnt++;
				end else begin
					want = due_results.pop_front();
					check_field("status", 8'(want.status), 8'(out_item.status));
					check_field("out_index", 8'(want.out_index), 8'(out_item.out_index));
					check_field("out_pool", 8'(want.out_pool), 8'(out_item.out_pool));
					check_field("ref_count", want.ref_count, out_item.ref_count);
					check_field("freed", 8'(want.freed), 8'(out_item.freed));
					check_field("acl_in_freed", 8'(want.acl_in_freed),
						8'(out_item.acl_in_freed));
				end
			end
			if (in_valid && in_ready)
				due_results.push_back(pool_step(in_item));
		end
		errors <= err_cnt;
		pending <= due_results.size();
	end

endmodule

/* tb/sv/refcounted_buffer_pool_manager_test.sv */
// Testbench top for the buffer pool manager: reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps
module refcounted_buffer_pool_manager_test
	import rbpm_pkg::*;
();

	localparam int  SETTLE    = 40;
	localparam int  LONG_HOLD = 200;
	localparam int  SAT_BEATS = 256;
	localparam time LIMIT     = 5ms;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_item;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_item;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [5:0] cfg_data;
	int         fail_count;
	int         pending_count;

	bit no_idle;
	int holds_asked;
	int holds_done;

	refcounted_buffer_pool_manager #(.POOL_SIZE(POOL_SIZE_DEF)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	rbpm_pool_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.errors   (fail_count),
		.pending  (pending_count)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#(LIMIT);
		$display("tb: failure");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic in_item_t rand_req();
		in_item_t it;
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			it.op = OP_INIT;
		else if (r < 36)
			it.op = OP_ALLOC;
		else if (r < 58)
			it.op = OP_ADDREF;
		else
			it.op = OP_RELEASE;
		it.in_interrupt = 1'($urandom_range(0, 1));
		it.buf_type = 2'($urandom_range(0, 3));
		it.buffer_index = 5'($urandom_range(0, 31));
		return it;
	endfunction

	task automatic send_beat(input in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic issue(input logic [1:0] op, input logic irq, input logic [1:0] btype,
			input logic [4:0] idx);
		in_item_t it;
		it.op = op;
		it.in_interrupt = irq;
		it.buf_type = btype;
		it.buffer_index = idx;
		send_beat(it);
	endtask

	// wait until every result has come back and the block has settled
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [5:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// result side flow control
	initial begin
		int n;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds_done != holds_asked) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_done++;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				out_ready <= 1'b1;
				n = $urandom_range(1, 8);
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		logic [5:0] rsv;
		logic [4:0] first;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_data = 6'd0;
		no_idle = 1'b0;
		holds_asked = 0;
		holds_done = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_cfg(6'd63);

		// before init: empty lists, no entry in use
		issue(OP_ALLOC, 1'b0, 2'd0, 5'd0);
		issue(OP_ALLOC, 1'b1, 2'd3, 5'd31);
		issue(OP_ADDREF, 1'b0, 2'd0, 5'd31);
		issue(OP_RELEASE, 1'b1, 2'd3, 5'd0);
		drain();
		write_cfg(6'd0);
		rsv = 6'($urandom_range(3, 12));
		write_cfg(rsv);

		issue(OP_INIT, 1'b0, 2'd0, 5'd0);
		issue(OP_INIT, 1'b1, 2'd3, 5'd31);

		first = 5'(31 - rsv);
		issue(OP_ALLOC, 1'b0, TYPE_ACL_IN, 5'd0);
		issue(OP_ADDREF, 1'b0, 2'd0, first);
		issue(OP_ADDREF, 1'b1, 2'd1, first);
		repeat (3) issue(OP_RELEASE, 1'b0, 2'd0, first);
		issue(OP_RELEASE, 1'b1, 2'd2, first);
		issue(OP_ADDREF, 1'b0, 2'd0, first);
		issue(OP_ALLOC, 1'b1, 2'd2, 5'd17);
		issue(OP_RELEASE, 1'b0, 2'd0, first);

		// empty the general list, then the reserve list, then run dry
		repeat (40) issue(OP_ALLOC, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
			5'($urandom_range(0, 31)));

		// entry 0 belongs to the general pool and is now in use: drive its count into saturation
		repeat (SAT_BEATS) issue(OP_ADDREF, 1'($urandom_range(0, 1)),
			2'($urandom_range(0, 3)), 5'd0);
		repeat (3) issue(OP_RELEASE, 1'b0, 2'd0, 5'd0);

		for (int k = 0; k < 150; k++) begin
			if (k == 30)
				holds_asked++;
			if (k == 80)
				no_idle = 1'b1;
			if (k == 120)
				no_idle = 1'b0;
			if (k == 130)
				drain();
			send_beat(rand_req());
		end
		drain();
		write_cfg(6'd32);

		holds_asked++;
		for (int k = 0; k < 90; k++)
			send_beat(rand_req());
		drain();
		write_cfg(6'd63);

		if (fail_count == 0 && pending_count == 0) begin
			$display("tb: success");
		end else begin
			if (pending_count != 0)
				$error("%0d results never arrived", pending_count);
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/rbpm_pkg.sv
rtl/rbpm_ram.sv
rtl/refcounted_buffer_pool_manager.sv
tb/sv/rbpm_pool_checker.sv
tb/sv/refcounted_buffer_pool_manager_test.sv
